FILE: hdl/aat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aat_pkg
// Types and constants shared by the box transform and its testbench.
// ----------------------------------------------------------------------------
package aat_pkg;

  localparam int unsigned CoordW   = 32;  // signed Q16.16
  localparam int unsigned EntryW   = 16;  // signed Q4.12
  localparam int unsigned FracSh   = 12;  // fraction bits of a matrix entry
  localparam int unsigned ProdW    = CoordW + EntryW;
  localparam int unsigned AccW     = ProdW + 2;
  localparam int unsigned QuotW    = AccW - FracSh;
  localparam int unsigned ColW     = 3 * EntryW;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = ColW;
  localparam int unsigned RoundBias = 1 << (FracSh - 1);

  // reset matrix is the identity
  localparam logic [ColW-1:0] MatrixXRst = 48'h0000_0000_1000;
  localparam logic [ColW-1:0] MatrixYRst = 48'h0000_1000_0000;
  localparam logic [ColW-1:0] MatrixZRst = 48'h1000_0000_0000;

  typedef enum logic [CfgAddrW-1:0] {
    CFG_MATRIX_X = 3'd0,
    CFG_MATRIX_Y = 3'd1,
    CFG_MATRIX_Z = 3'd2,
    CFG_SHIFT_X  = 3'd3,
    CFG_SHIFT_Y  = 3'd4,
    CFG_SHIFT_Z  = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CoordW-1:0] box_min_x;
    logic signed [CoordW-1:0] box_min_y;
    logic signed [CoordW-1:0] box_min_z;
    logic signed [CoordW-1:0] box_max_x;
    logic signed [CoordW-1:0] box_max_y;
    logic signed [CoordW-1:0] box_max_z;
    logic                     box_empty;
  } box_t;

  typedef struct packed {
    logic signed [CoordW-1:0] out_min_x;
    logic signed [CoordW-1:0] out_min_y;
    logic signed [CoordW-1:0] out_min_z;
    logic signed [CoordW-1:0] out_max_x;
    logic signed [CoordW-1:0] out_max_y;
    logic signed [CoordW-1:0] out_max_z;
    logic                     out_empty;
    logic                     saturated;
  } result_t;

  typedef struct packed {
    logic [CfgAddrW-1:0] addr;
    logic [CfgDataW-1:0] wdata;
  } cfg_t;

endpackage

FILE: hdl/aat_stream_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aat_stream_if
// Valid/ready channel carrying one payload beat per handshake.
// ----------------------------------------------------------------------------
interface aat_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

FILE: hdl/aabb_affine_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aabb_affine_transform
// Bounds an axis-aligned box after a 3x3 linear map plus translation
// (corner selection by entry sign), rounded to Q16.16 with saturation.
// ----------------------------------------------------------------------------
//  channel  dir  payload   beat
//  box_i    in   box_t     one box, min/max corners and empty flag
//  res_o    out  result_t  one transformed box per input box
//  cfg_i    in   cfg_t     register write, always ready
//
//  one box per cycle sustained while res_o is ready; the stages are the input
//  register, the product register (18 multipliers of 32x16) and the result
//  register. each stage loads when it is empty or the one after it moves, so
//  a stalled result lets the earlier stages take new beats only into bubbles.
//  reset clears the stage valid bits and loads the identity transform.
// ----------------------------------------------------------------------------
module aabb_affine_transform (
  input logic          clk_i,
  input logic          rst_ni,
  aat_stream_if.sink   box_i,
  aat_stream_if.source res_o,
  aat_stream_if.sink   cfg_i
);
  import aat_pkg::*;

  typedef struct packed {
    logic signed [CoordW-1:0] value;
    logic                     sat;
  } bound_t;

  function automatic bound_t round_clamp(input logic signed [AccW-1:0] acc);
    logic signed [AccW-1:0]  rnd;
    logic signed [QuotW-1:0] quo;
    bound_t                  res;
    rnd = acc + AccW'(RoundBias);
    quo = rnd[AccW-1:FracSh];
    if (&quo[QuotW-1:CoordW-1] || ~|quo[QuotW-1:CoordW-1]) begin
      res.value = quo[CoordW-1:0];
      res.sat   = 1'b0;
    end else begin
      res.value = quo[QuotW-1] ? {1'b1, {(CoordW-1){1'b0}}} : {1'b0, {(CoordW-1){1'b1}}};
      res.sat   = 1'b1;
    end
    return res;
  endfunction

  // configuration registers
  logic [ColW-1:0]          matrix_q [3];
  logic signed [CoordW-1:0] shift_q  [3];

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      matrix_q[0] <= MatrixXRst;
      matrix_q[1] <= MatrixYRst;
      matrix_q[2] <= MatrixZRst;
      shift_q[0]  <= '0;
      shift_q[1]  <= '0;
      shift_q[2]  <= '0;
    end else if (cfg_i.valid) begin
      unique case (cfg_reg_e'(cfg_i.payload.addr))
        CFG_MATRIX_X: matrix_q[0] <= cfg_i.payload.wdata;
        CFG_MATRIX_Y: matrix_q[1] <= cfg_i.payload.wdata;
        CFG_MATRIX_Z: matrix_q[2] <= cfg_i.payload.wdata;
        CFG_SHIFT_X:  shift_q[0]  <= cfg_i.payload.wdata[CoordW-1:0];
        CFG_SHIFT_Y:  shift_q[1]  <= cfg_i.payload.wdata[CoordW-1:0];
        CFG_SHIFT_Z:  shift_q[2]  <= cfg_i.payload.wdata[CoordW-1:0];
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic s0_valid_q, s1_valid_q, out_valid_q;
  logic s0_en, s1_en, out_en;

  assign out_en      = !out_valid_q || res_o.ready;
  assign s1_en       = !s1_valid_q || out_en;
  assign s0_en       = !s0_valid_q || s1_en;
  assign box_i.ready = s0_en;
  assign res_o.valid = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s0_en)  s0_valid_q  <= box_i.valid;
      if (s1_en)  s1_valid_q  <= s0_valid_q;
      if (out_en) out_valid_q <= s1_valid_q;
    end
  end

  // input register
  box_t box_q;

  always_ff @(posedge clk_i) begin
    if (s0_en) begin
      box_q <= box_i.payload;
    end
  end

  // products: the sign of each entry picks which corner feeds each bound
  logic signed [CoordW-1:0] corner_min [3];
  logic signed [CoordW-1:0] corner_max [3];
  logic signed [ProdW-1:0]  prod_lo_d [3][3];
  logic signed [ProdW-1:0]  prod_hi_d [3][3];
  logic signed [ProdW-1:0]  prod_lo_q [3][3];
  logic signed [ProdW-1:0]  prod_hi_q [3][3];
  box_t                     box_s1_q;

  assign corner_min[0] = box_q.box_min_x;
  assign corner_min[1] = box_q.box_min_y;
  assign corner_min[2] = box_q.box_min_z;
  assign corner_max[0] = box_q.box_max_x;
  assign corner_max[1] = box_q.box_max_y;
  assign corner_max[2] = box_q.box_max_z;

  always_comb begin
    logic signed [EntryW-1:0] entry;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        entry = matrix_q[c][EntryW*r +: EntryW];
        if (entry[EntryW-1]) begin
          prod_lo_d[r][c] = corner_max[c] * entry;
          prod_hi_d[r][c] = corner_min[c] * entry;
        end else begin
          prod_lo_d[r][c] = corner_min[c] * entry;
          prod_hi_d[r][c] = corner_max[c] * entry;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en) begin
      prod_lo_q <= prod_lo_d;
      prod_hi_q <= prod_hi_d;
      box_s1_q  <= box_q;
    end
  end

  // sum, round, clamp and order each output pair; an empty box passes its corners through
  logic signed [CoordW-1:0] bound_min [3];
  logic signed [CoordW-1:0] bound_max [3];
  logic [2:0]               row_sat;
  result_t                  res_d, res_q;

  always_comb begin
    logic signed [AccW-1:0] acc_lo, acc_hi, shift_term;
    bound_t                 b_lo, b_hi;
    for (int r = 0; r < 3; r++) begin
      shift_term = AccW'(shift_q[r]) <<< FracSh;
      acc_lo = AccW'(prod_lo_q[r][0]) + AccW'(prod_lo_q[r][1])
             + AccW'(prod_lo_q[r][2]) + shift_term;
      acc_hi = AccW'(prod_hi_q[r][0]) + AccW'(prod_hi_q[r][1])
             + AccW'(prod_hi_q[r][2]) + shift_term;
      b_lo = round_clamp(acc_lo);
      b_hi = round_clamp(acc_hi);
      row_sat[r] = b_lo.sat | b_hi.sat;
      // corners given out of order can swap the bounds
      if (b_lo.value > b_hi.value) begin
        bound_min[r] = b_hi.value;
        bound_max[r] = b_lo.value;
      end else begin
        bound_min[r] = b_lo.value;
        bound_max[r] = b_hi.value;
      end
    end

    if (box_s1_q.box_empty) begin
      res_d.out_min_x = box_s1_q.box_min_x;
      res_d.out_min_y = box_s1_q.box_min_y;
      res_d.out_min_z = box_s1_q.box_min_z;
      res_d.out_max_x = box_s1_q.box_max_x;
      res_d.out_max_y = box_s1_q.box_max_y;
      res_d.out_max_z = box_s1_q.box_max_z;
      res_d.out_empty = 1'b1;
      res_d.saturated = 1'b0;
    end else begin
      res_d.out_min_x = bound_min[0];
      res_d.out_min_y = bound_min[1];
      res_d.out_min_z = bound_min[2];
      res_d.out_max_x = bound_max[0];
      res_d.out_max_y = bound_max[1];
      res_d.out_max_z = bound_max[2];
      res_d.out_empty = 1'b0;
      res_d.saturated = |row_sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      res_q <= res_d;
    end
  end

  assign res_o.payload = res_q;

endmodule

FILE: sim/tb_aabb_affine_transform.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aabb_affine_transform
// Streams boxes through the transform under several matrix/translation
// settings, idle and stall patterns. A scoreboard predicts each bounding box from
// its own copy of the registers and checks the result beats in order.
// ----------------------------------------------------------------------------
import aat_pkg::*;

class box_bound_board;
  localparam longint CoordMax = (longint'(1) <<< (CoordW - 1)) - 1;
  localparam longint CoordMin = -(longint'(1) <<< (CoordW - 1));

  logic [ColW-1:0]   col_q[3];
  logic [CoordW-1:0] shift_q[3];
  result_t           bound_q[$];
  int unsigned       n_mismatch;

  function new();
    col_q[0] = MatrixXRst;
    col_q[1] = MatrixYRst;
    col_q[2] = MatrixZRst;
    foreach (shift_q[i]) shift_q[i] = '0;
    n_mismatch = 0;
  endfunction

  function void write_reg(logic [CfgAddrW-1:0] addr, logic [CfgDataW-1:0] data);
    case (addr)
      CFG_MATRIX_X: col_q[0] = data;
      CFG_MATRIX_Y: col_q[1] = data;
      CFG_MATRIX_Z: col_q[2] = data;
      CFG_SHIFT_X:  shift_q[0] = data[CoordW-1:0];
      CFG_SHIFT_Y:  shift_q[1] = data[CoordW-1:0];
      CFG_SHIFT_Z:  shift_q[2] = data[CoordW-1:0];
      default: ;
    endcase
  endfunction

  // round half up to Q16.16, then clamp to 32 bits
  function longint round_sat(input longint acc, inout bit sat);
    longint q;
    q = (acc + longint'(RoundBias)) >>> FracSh;
    if (q > CoordMax) begin
      sat = 1'b1;
      q = CoordMax;
    end else if (q < CoordMin) begin
      sat = 1'b1;
      q = CoordMin;
    end
    return q;
  endfunction

  function result_t predict_bounds(box_t b);
    result_t           r;
    longint            lo_c[3], hi_c[3];
    longint            e, t, acc_lo, acc_hi, a, z;
    logic [CoordW-1:0] lo_o[3], hi_o[3];
    bit                sat;
    if (b.box_empty) begin
      r = '{b.box_min_x, b.box_min_y, b.box_min_z,
            b.box_max_x, b.box_max_y, b.box_max_z, 1'b1, 1'b0};
      return r;
    end
    lo_c = '{longint'(b.box_min_x), longint'(b.box_min_y), longint'(b.box_min_z)};
    hi_c = '{longint'(b.box_max_x), longint'(b.box_max_y), longint'(b.box_max_z)};
    sat = 1'b0;
    for (int row = 0; row < 3; row++) begin
      acc_lo = 0;
      acc_hi = 0;
      for (int col = 0; col < 3; col++) begin
        e = longint'($signed(col_q[col][row*EntryW +: EntryW]));
        // negative entry swaps which corner feeds each bound
        if (e >= 0) begin
          acc_lo += lo_c[col] * e;
          acc_hi += hi_c[col] * e;
        end else begin
          acc_lo += hi_c[col] * e;
          acc_hi += lo_c[col] * e;
        end
      end
      t = longint'($signed(shift_q[row])) <<< FracSh;
      a = round_sat(acc_lo + t, sat);
      z = round_sat(acc_hi + t, sat);
      if (a > z) begin
        lo_o[row] = z[CoordW-1:0];
        hi_o[row] = a[CoordW-1:0];
      end else begin
        lo_o[row] = a[CoordW-1:0];
        hi_o[row] = z[CoordW-1:0];
      end
    end
    r = '{lo_o[0], lo_o[1], lo_o[2], hi_o[0], hi_o[1], hi_o[2], 1'b0, sat};
    return r;
  endfunction

  function void note_box(box_t b);
    bound_q.push_back(predict_bounds(b));
  endfunction

  function int pending();
    return bound_q.size();
  endfunction

  task report_mismatch(string what);
    $display("[%0t] mismatch: %s", $time, what);
    n_mismatch++;
  endtask

  task check_result(result_t r);
    result_t           want;
    logic [CoordW-1:0] got_f[8], want_f[8];
    string             tag[8];
    if (bound_q.size() == 0) begin
      report_mismatch("result beat with no box pending");
      return;
    end
    want = bound_q.pop_front();
    tag = '{"out_min_x", "out_min_y", "out_min_z", "out_max_x", "out_max_y",
            "out_max_z", "out_empty", "saturated"};
    got_f = '{r.out_min_x, r.out_min_y, r.out_min_z, r.out_max_x, r.out_max_y,
              r.out_max_z, {31'b0, r.out_empty}, {31'b0, r.saturated}};
    want_f = '{want.out_min_x, want.out_min_y, want.out_min_z, want.out_max_x,
               want.out_max_y, want.out_max_z, {31'b0, want.out_empty},
               {31'b0, want.saturated}};
    for (int i = 0; i < 8; i++) begin
      if (got_f[i] !== want_f[i])
        report_mismatch($sformatf("%s got %h want %h", tag[i], got_f[i], want_f[i]));
    end
  endtask
endclass

module tb_aabb_affine_transform;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned SegItems      = 88;
  localparam logic [CoordW-1:0] CoordHi = 32'h7FFF_FFFF;
  localparam logic [CoordW-1:0] CoordLo = 32'h8000_0000;

  logic clk_i = 1'b0;
  logic rst_ni;

  aat_stream_if #(.payload_t(box_t))    box_if ();
  aat_stream_if #(.payload_t(result_t)) res_if ();
  aat_stream_if #(.payload_t(cfg_t))    cfg_if ();

  aabb_affine_transform dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .box_i  (box_if),
    .res_o  (res_if),
    .cfg_i  (cfg_if)
  );

  box_bound_board    sb;
  int unsigned       idle_pct;
  int unsigned       stall_pct;
  int unsigned       quiet_cycles;
  logic [CfgDataW-1:0] reg_plan[6];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result sink back-pressure
  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // beat monitor and watchdog
  always @(posedge clk_i) begin
    bit busy;
    if (rst_ni) begin
      busy = 1'b0;
      if (box_if.valid && box_if.ready) begin
        sb.note_box(box_if.payload);
        busy = 1'b1;
      end
      if (res_if.valid && res_if.ready) begin
        sb.check_result(res_if.payload);
        busy = 1'b1;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        sb.write_reg(cfg_if.payload.addr, cfg_if.payload.wdata);
        busy = 1'b1;
      end
      quiet_cycles = busy ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("tb_aabb_affine_transform NOT OK");
        $finish;
      end
    end
  end

  function automatic box_t mk_box(logic [CoordW-1:0] x0, y0, z0, x1, y1, z1, logic mt);
    box_t b;
    b = '{x0, y0, z0, x1, y1, z1, mt};
    return b;
  endfunction

  function automatic logic [CoordW-1:0] rand_coord();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(4))
          0: return CoordLo;
          1: return CoordHi;
          2: return '0;
          3: return '1;
          default: return 32'd1;
        endcase
      end
      1, 2: return $urandom();
      default: return $urandom_range(0, 32'h40_0000) - 32'h20_0000;
    endcase
  endfunction

  function automatic logic [EntryW-1:0] rand_entry();
    case ($urandom_range(7))
      0: return '0;
      1: return 16'h8000;
      2: return 16'h7FFF;
      3: return 16'h1000;
      4: return 16'hF000;
      5: return 16'hFFFF;
      default: return EntryW'($urandom());
    endcase
  endfunction

  function automatic box_t rand_box();
    box_t b;
    logic signed [CoordW-1:0] tmp;
    b = mk_box(rand_coord(), rand_coord(), rand_coord(),
               rand_coord(), rand_coord(), rand_coord(), $urandom_range(99) < 10);
    // mostly well-ordered corners
    if ($urandom_range(99) < 85) begin
      if (b.box_min_x > b.box_max_x) begin
        tmp = b.box_min_x; b.box_min_x = b.box_max_x; b.box_max_x = tmp;
      end
      if (b.box_min_y > b.box_max_y) begin
        tmp = b.box_min_y; b.box_min_y = b.box_max_y; b.box_max_y = tmp;
      end
      if (b.box_min_z > b.box_max_z) begin
        tmp = b.box_min_z; b.box_min_z = b.box_max_z; b.box_max_z = tmp;
      end
    end
    return b;
  endfunction

  function automatic void plan_random();
    for (int c = CFG_MATRIX_X; c <= CFG_MATRIX_Z; c++)
      reg_plan[c] = {rand_entry(), rand_entry(), rand_entry()};
    for (int s = CFG_SHIFT_X; s <= CFG_SHIFT_Z; s++)
      reg_plan[s] = {16'($urandom()), rand_coord()};
  endfunction

  task automatic send_box(box_t b);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      box_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    box_if.valid   <= 1'b1;
    box_if.payload <= b;
    do @(posedge clk_i); while (!box_if.ready);
  endtask

  // hold off new boxes until every pending result has drained
  task automatic drain();
    @(negedge clk_i);
    box_if.valid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk_i);
  endtask

  // writes every register from reg_plan, then the unused indexes with noise
  task automatic program_regs();
    cfg_t w;
    for (int a = 0; a < (1 << CfgAddrW); a++) begin
      w.addr = a[CfgAddrW-1:0];
      if (a <= CFG_SHIFT_Z)
        w.wdata = reg_plan[a];
      else
        w.wdata = CfgDataW'({$urandom(), $urandom()});
      @(negedge clk_i);
      cfg_if.valid   <= 1'b1;
      cfg_if.payload <= w;
      do @(posedge clk_i); while (!cfg_if.ready);
    end
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    rst_ni         = 1'b0;
    box_if.valid   = 1'b0;
    box_if.payload = '0;
    cfg_if.valid   = 1'b0;
    cfg_if.payload = '0;
    res_if.ready   = 1'b0;
    idle_pct       = 0;
    stall_pct      = 0;
    quiet_cycles   = 0;
    sb = new();
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // identity transform out of reset
    send_box(mk_box('0, '0, '0, '0, '0, '0, 1'b0));
    send_box(mk_box(CoordLo, CoordLo, CoordLo, CoordHi, CoordHi, CoordHi, 1'b0));
    send_box(mk_box(CoordHi, CoordHi, CoordHi, CoordLo, CoordLo, CoordLo, 1'b0));
    send_box(mk_box(CoordHi, CoordHi, CoordHi, CoordLo, CoordLo, CoordLo, 1'b1));
    send_box(mk_box(32'h1234_5678, '1, 32'h8765_4321, '0, 32'd7, CoordLo, 1'b1));
    send_box(mk_box(-32'sh1_0000, 32'h8000, 32'd3, 32'h2_0000, 32'h1_8000,
                    32'h7FFF_0000, 1'b0));
    send_box(mk_box('1, '1, '1, 32'd1, 32'd1, 32'd1, 1'b0));
    drain();

    // largest positive entries and translation
    reg_plan[CFG_MATRIX_X] = {3{16'h7FFF}};
    reg_plan[CFG_MATRIX_Y] = {3{16'h7FFF}};
    reg_plan[CFG_MATRIX_Z] = {3{16'h7FFF}};
    reg_plan[CFG_SHIFT_X]  = {16'hFFFF, CoordHi};
    reg_plan[CFG_SHIFT_Y]  = {16'h0000, CoordHi};
    reg_plan[CFG_SHIFT_Z]  = {16'hA5A5, CoordHi};
    program_regs();
    send_box(mk_box('0, '0, '0, '0, '0, '0, 1'b0));
    send_box(mk_box(CoordHi, CoordHi, CoordHi, CoordHi, CoordHi, CoordHi, 1'b0));
    send_box(mk_box(CoordLo, CoordLo, CoordLo, CoordHi, CoordHi, CoordHi, 1'b0));
    send_box(mk_box(CoordLo, CoordLo, CoordLo, CoordHi, CoordHi, CoordHi, 1'b1));
    send_box(mk_box(32'd1, 32'd1, 32'd1, 32'd2, 32'd2, 32'd2, 1'b0));
    drain();

    // most negative entries and translation
    reg_plan[CFG_MATRIX_X] = {3{16'h8000}};
    reg_plan[CFG_MATRIX_Y] = {3{16'h8000}};
    reg_plan[CFG_MATRIX_Z] = {3{16'h8000}};
    reg_plan[CFG_SHIFT_X]  = {16'h0000, CoordLo};
    reg_plan[CFG_SHIFT_Y]  = {16'hFFFF, CoordLo};
    reg_plan[CFG_SHIFT_Z]  = {16'h5A5A, CoordLo};
    program_regs();
    send_box(mk_box('0, '0, '0, '0, '0, '0, 1'b0));
    send_box(mk_box(CoordLo, CoordLo, CoordLo, CoordHi, CoordHi, CoordHi, 1'b0));
    send_box(mk_box(32'h10_0000, 32'h1, 32'h7_0000, 32'h20_0000, 32'h3, 32'h9_0000, 1'b0));
    send_box(mk_box(32'h5_0000, 32'h5_0000, 32'h5_0000, '1, '1, '1, 1'b0));
    drain();

    // mixed signs, zero entries and half-lsb rounding
    reg_plan[CFG_MATRIX_X] = {16'h0000, 16'hF800, 16'h0800};
    reg_plan[CFG_MATRIX_Y] = {16'h1000, 16'h0000, 16'hF000};
    reg_plan[CFG_MATRIX_Z] = {16'h7FFF, 16'h8000, 16'h0000};
    reg_plan[CFG_SHIFT_X]  = {16'h0000, 32'd1};
    reg_plan[CFG_SHIFT_Y]  = {16'h0000, 32'hFFFF_FFFF};
    reg_plan[CFG_SHIFT_Z]  = {16'h0000, 32'h1_2345};
    program_regs();
    send_box(mk_box(32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 32'd1, 1'b0));
    send_box(mk_box('1, '1, '1, '1, '1, '1, 1'b0));
    send_box(mk_box(-32'sd1, -32'sd2, -32'sd3, 32'd1, 32'd2, 32'd3, 1'b0));
    send_box(mk_box(CoordLo, '0, -32'sd5, CoordHi, '0, 32'd5, 1'b0));
    send_box(mk_box(32'd9, 32'd8, 32'd7, 32'd1, 32'd2, 32'd3, 1'b1));

    for (int p = 0; p < 4; p++) begin
      case (p)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 17; stall_pct = 17; end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        drain();
        plan_random();
        program_regs();
        for (int i = 0; i < SegItems; i++) begin
          if (i == SegItems / 2) drain();
          send_box(rand_box());
        end
      end
    end

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.n_mismatch == 0 && sb.pending() == 0)
      $display("tb_aabb_affine_transform OK");
    else
      $display("tb_aabb_affine_transform NOT OK");
    $finish;
  end

endmodule
